// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the serial frame receiver with acknowledge.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h01;
    localparam logic [7:0] KIND_ACK    = 8'hFF;
    localparam logic [7:0] ACK_LEN_LO  = 8'h04;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    // Overhead added to a received frame's length field, and the acknowledge frame size
    localparam int unsigned FRAME_OVERHEAD = 8;
    localparam int unsigned ACK_BYTES      = 12;

    // Byte positions within a received frame
    localparam logic [16:0] POS_SYNC_FIRST  = 17'd0;
    localparam logic [16:0] POS_SYNC_SECOND = 17'd1;
    localparam logic [16:0] POS_KIND        = 17'd2;
    localparam logic [16:0] POS_LEN_LO      = 17'd3;
    localparam logic [16:0] POS_LEN_HI      = 17'd4;
    localparam logic [16:0] POS_ID_LO       = 17'd5;
    localparam logic [16:0] POS_ID_HI       = 17'd6;
    localparam logic [16:0] POS_BODY        = 17'd7;

    // One pending acknowledge
    typedef struct packed {
        logic [7:0] kind;
        logic [7:0] id_lo;
        logic [7:0] id_hi;
    } ack_req_t;

endpackage

`default_nettype wire

// ===== rtl/sfr_parser.sv =====
// Frame parser: tracks byte position; requests an acknowledge at non-FF frame end.
`timescale 1ns / 1ps
`default_nettype none

module sfr_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [7:0]      rx_data,
    output logic                 push,
    output sfr_pkg::ack_req_t    req
);
    import sfr_pkg::*;

    logic [16:0] pos_reg, pos_next;
    logic [16:0] total_reg, total_next;
    logic [7:0]  held_first_reg, held_first_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  id_lo_reg, id_lo_next;
    logic [7:0]  id_hi_reg, id_hi_next;
    logic        sync_bad;
    logic        frame_done;

    // Decode the current word against the frame position
    always_comb
    begin
        pos_next        = pos_reg;
        total_next      = total_reg;
        held_first_next = held_first_reg;
        len_lo_next     = len_lo_reg;
        kind_next       = kind_reg;
        id_lo_next      = id_lo_reg;
        id_hi_next      = id_hi_reg;
        sync_bad        = 1'b0;
        frame_done      = 1'b0;
        push            = 1'b0;
        if (take)
        begin
            case (pos_reg)
                POS_SYNC_FIRST:  held_first_next = rx_data;
                POS_SYNC_SECOND: sync_bad = (held_first_reg != SYNC_FIRST) ||
                                            (rx_data != SYNC_SECOND);
                POS_KIND:        kind_next = rx_data;
                POS_LEN_LO:      len_lo_next = rx_data;
                POS_LEN_HI:      total_next = {1'b0, rx_data, len_lo_reg} +
                                              17'(FRAME_OVERHEAD);
                POS_ID_LO:       id_lo_next = rx_data;
                POS_ID_HI:       id_hi_next = rx_data;
                default:         ;
            endcase
            frame_done = (pos_reg >= POS_BODY) &&
                         (({1'b0, pos_reg} + 18'd1) >= {1'b0, total_reg});
            if (sync_bad)
            begin
                pos_next = '0;
            end
            else if (frame_done)
            begin
                pos_next = '0;
                push     = (kind_reg != KIND_ACK);
            end
            else
            begin
                pos_next = pos_reg + 17'd1;
            end
        end
    end

    assign req.kind  = kind_reg;
    assign req.id_lo = id_lo_reg;
    assign req.id_hi = id_hi_reg;

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            total_reg      <= '0;
            held_first_reg <= '0;
            len_lo_reg     <= '0;
            kind_reg       <= '0;
            id_lo_reg      <= '0;
            id_hi_reg      <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            total_reg      <= total_next;
            held_first_reg <= held_first_next;
            len_lo_reg     <= len_lo_next;
            kind_reg       <= kind_next;
            id_lo_reg      <= id_lo_next;
            id_hi_reg      <= id_hi_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfr_ack_fifo.sv =====
// Small queue of pending acknowledge requests.
`timescale 1ns / 1ps
`default_nettype none

module sfr_ack_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sfr_pkg::ack_req_t push_req,
    input  wire logic              pop,
    output sfr_pkg::ack_req_t      head,
    output logic                   empty,
    output logic                   full
);
    import sfr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ack_req_t               mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store request entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfr_ack_tx.sv =====
// Acknowledge serializer: turns one request into twelve registered output words.
`timescale 1ns / 1ps
`default_nettype none

module sfr_ack_tx (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sfr_pkg::ack_req_t req,
    input  wire logic              req_avail,
    output logic                   req_pop,
    output logic [7:0]             ack_data,
    output logic                   ack_end,
    output logic [7:0]             frame_kind,
    output logic                   ack_valid,
    input  wire logic              ack_ready
);
    import sfr_pkg::*;

    localparam logic [3:0] LAST_IDX = 4'(ACK_BYTES - 1);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       end_reg, end_next;
    logic [7:0] kind_reg, kind_next;
    logic       slot_free;
    logic       load;
    logic [7:0] hdr_sum;
    logic [7:0] cur_byte;

    assign slot_free = !valid_reg || ack_ready;
    assign load      = slot_free && req_avail;
    assign req_pop   = load && (idx_reg == LAST_IDX);

    // Sum of the first eleven bytes; the header constants fold together
    assign hdr_sum = SYNC_FIRST + SYNC_SECOND + KIND_ACK + ACK_LEN_LO + SYNC_FIRST +
                     req.id_lo + req.id_hi;

    // Select the acknowledge byte for the current index
    always_comb
    begin
        case (idx_reg)
            4'd0:    cur_byte = SYNC_FIRST;
            4'd1:    cur_byte = SYNC_SECOND;
            4'd2:    cur_byte = KIND_ACK;
            4'd3:    cur_byte = ACK_LEN_LO;
            4'd4:    cur_byte = ZERO_BYTE;
            4'd5:    cur_byte = req.id_lo;
            4'd6:    cur_byte = req.id_hi;
            4'd7:    cur_byte = SYNC_FIRST;
            4'd8:    cur_byte = ZERO_BYTE;
            4'd9:    cur_byte = ZERO_BYTE;
            4'd10:   cur_byte = ZERO_BYTE;
            4'd11:   cur_byte = 8'd0 - hdr_sum;
            default: cur_byte = ZERO_BYTE;
        endcase
    end

    // Load the output register when it is free, drop the word when taken
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        end_next   = end_reg;
        kind_next  = kind_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = cur_byte;
            end_next   = (idx_reg == LAST_IDX);
            kind_next  = req.kind;
            idx_next   = (idx_reg == LAST_IDX) ? 4'd0 : idx_reg + 4'd1;
        end
        else if (slot_free)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        end_reg  <= end_next;
        kind_reg <= kind_next;
    end

    assign ack_valid  = valid_reg;
    assign ack_data   = data_reg;
    assign ack_end    = end_reg;
    assign frame_kind = kind_reg;

endmodule

`default_nettype wire

// ===== rtl/serial_frame_receiver_with_ack.sv =====
// Top level of the serial frame receiver with acknowledge.
//
// Input channel rx_*: one received serial byte per word. Frames are A5 01,
// type, 16-bit length (low first), 16-bit id (low first), payload. A bad sync
// pair drops both bytes. Payload bytes are consumed and discarded.
// Output channel ack_*: for every completed frame whose type is not FF, twelve
// words A5 01 FF 04 00 id_lo id_hi A5 00 00 00 cks, ack_end high on the last,
// frame_kind carrying the received type on all twelve.
// Input words are taken whenever offered while rx_ready is high; rx_ready is low only while the
// request queue (ACK_DEPTH entries) is full. A frame's request is queued when
// its last byte is taken, and its first acknowledge word is loaded from the queue
// head into the output register; words follow one per cycle while ack_ready is
// high, 12 words per request. Sustained rate is one rx word per cycle until
// acknowledges back up, as they do with minimum 8-word frames that each yield 12 words.
// When ack_ready is low the output word holds and queued requests wait;
// input is still taken while the queue has room.
// Reset clears the frame position, the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_with_ack #(
    parameter int unsigned ACK_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] rx_data,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    output logic [7:0]      ack_data,
    output logic            ack_end,
    output logic [7:0]      frame_kind,
    output logic            ack_valid,
    input  wire logic       ack_ready
);
    import sfr_pkg::*;

    logic     take;
    logic     push;
    ack_req_t push_req;
    ack_req_t head;
    logic     q_empty;
    logic     q_full;
    logic     pop;

    assign rx_ready = !q_full;
    assign take     = rx_valid && rx_ready;

    sfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_data (rx_data),
        .push    (push),
        .req     (push_req)
    );

    sfr_ack_fifo #(
        .DEPTH (ACK_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sfr_ack_tx u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (head),
        .req_avail  (!q_empty),
        .req_pop    (pop),
        .ack_data   (ack_data),
        .ack_end    (ack_end),
        .frame_kind (frame_kind),
        .ack_valid  (ack_valid),
        .ack_ready  (ack_ready)
    );

endmodule

`default_nettype wire
